// ===== rtl/delayed_command_slot_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Delayed command slot queue assertion macros
// Shared assertion forms for the checker of the delayed command slot queue.
// ----------------------------------------------------------------------------
`ifndef DELAYED_COMMAND_SLOT_QUEUE_DEFINES_SVH
`define DELAYED_COMMAND_SLOT_QUEUE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define DCSQ_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define DCSQ_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/dcsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue package
// Sizes, control word layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcsq_pkg;

  localparam int QUEUE_SLOTS = 8;
  localparam int SLOT_W      = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int DATA_W      = 32;
  localparam int PADDR_W     = 3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(QUEUE_SLOTS - 1);

  localparam logic REG_REPLY_HANDLE = 1'b0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_INSERT = 2'd1,
    OP_FETCH  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STEP_IDLE      = 3'd0,
    STEP_TICK      = 3'd1,
    STEP_INS_SCAN  = 3'd2,
    STEP_EMPTY     = 3'd3,
    STEP_INS_WRITE = 3'd4,
    STEP_FET_SCAN  = 3'd5,
    STEP_FET_READ  = 3'd6
  } step_t;

  typedef enum logic [1:0] {
    COND_DISPATCH  = 2'd0,
    COND_GOTO      = 2'd1,
    COND_SCAN_FREE = 2'd2,
    COND_SCAN_DUE  = 2'd3
  } cond_t;

  typedef enum logic [1:0] {
    ACT_NONE     = 2'd0,
    ACT_TIME_INC = 2'd1,
    ACT_INSERT   = 2'd2,
    ACT_CLEAR    = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_OK   = 2'd1,
    EMIT_ZERO = 2'd2,
    EMIT_SLOT = 2'd3
  } emit_t;

  typedef struct packed {
    cond_t cond;
    act_t  act;
    emit_t emit;
    step_t hit_step;
    step_t miss_step;
  } ucode_word_t;

  typedef struct packed {
    logic              latch;
    act_t              act;
    emit_t             emit;
    logic [SLOT_W-1:0] idx;
  } dp_ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic slot_due;
  } dp_status_t;

  function automatic ucode_word_t ucode_rom(input step_t step);
    ucode_word_t w;
    w = '{COND_DISPATCH, ACT_NONE, EMIT_NONE, STEP_IDLE, STEP_IDLE};
    case (step)
      STEP_IDLE:      w = '{COND_DISPATCH,  ACT_NONE,     EMIT_NONE, STEP_IDLE,
                            STEP_IDLE};
      STEP_TICK:      w = '{COND_GOTO,      ACT_TIME_INC, EMIT_OK,   STEP_IDLE,
                            STEP_IDLE};
      STEP_INS_SCAN:  w = '{COND_SCAN_FREE, ACT_NONE,     EMIT_NONE, STEP_INS_WRITE,
                            STEP_EMPTY};
      STEP_EMPTY:     w = '{COND_GOTO,      ACT_NONE,     EMIT_ZERO, STEP_IDLE,
                            STEP_IDLE};
      STEP_INS_WRITE: w = '{COND_GOTO,      ACT_INSERT,   EMIT_OK,   STEP_IDLE,
                            STEP_IDLE};
      STEP_FET_SCAN:  w = '{COND_SCAN_DUE,  ACT_NONE,     EMIT_NONE, STEP_FET_READ,
                            STEP_EMPTY};
      STEP_FET_READ:  w = '{COND_GOTO,      ACT_CLEAR,    EMIT_SLOT, STEP_IDLE,
                            STEP_IDLE};
      default:        w = '{COND_GOTO,      ACT_NONE,     EMIT_NONE, STEP_IDLE,
                            STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t op_entry(input logic [1:0] op);
    step_t s;
    s = STEP_EMPTY;
    case (op)
      OP_TICK:   s = STEP_TICK;
      OP_INSERT: s = STEP_INS_SCAN;
      OP_FETCH:  s = STEP_FET_SCAN;
      default:   s = STEP_EMPTY;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dcsq_sequencer.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue sequencer
// Step counter, microcode lookup, conditional jumps and the slot scan index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcsq_sequencer import dcsq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] op,
  input  dp_status_t status,
  output logic       busy,
  output dp_ctrl_t   ctrl
);

  step_t             pc;
  step_t             pc_next;
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] idx_next;
  ucode_word_t       word;
  logic              hit;

  assign word = ucode_rom(pc);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= STEP_IDLE;
      idx <= '0;
    end else begin
      pc  <= pc_next;
      idx <= idx_next;
    end
  end

  always_comb begin
    pc_next  = pc;
    idx_next = idx;
    hit      = 1'b0;
    case (word.cond)
      COND_DISPATCH: begin
        if (start) begin
          pc_next  = op_entry(op);
          idx_next = '0;
        end
      end
      COND_GOTO: begin
        pc_next = word.hit_step;
      end
      COND_SCAN_FREE, COND_SCAN_DUE: begin
        hit = (word.cond == COND_SCAN_FREE) ? status.slot_free : status.slot_due;
        if (hit) begin
          pc_next = word.hit_step;
        end else if (idx == SLOT_LAST) begin
          pc_next = word.miss_step;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        pc_next = STEP_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = (pc != STEP_IDLE);
    ctrl.latch = (word.cond == COND_DISPATCH) && start;
    ctrl.act   = word.act;
    ctrl.emit  = word.emit;
    ctrl.idx   = idx;
  end

endmodule

`default_nettype wire

// ===== rtl/dcsq_datapath.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue datapath
// Slot table, time counter, operand latches, slot tests and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcsq_datapath import dcsq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dp_ctrl_t          ctrl,
  input  logic [DATA_W-1:0] command,
  input  logic [DATA_W-1:0] param_handle,
  input  logic [DATA_W-1:0] delay,
  input  logic [DATA_W-1:0] reply_handle,
  output dp_status_t        status,
  output logic              done,
  output logic              success,
  output logic [DATA_W-1:0] due_command,
  output logic [DATA_W-1:0] due_param_in,
  output logic [DATA_W-1:0] due_param_out
);

  logic [DATA_W-1:0] time_now;
  logic [DATA_W-1:0] cmd_hold;
  logic [DATA_W-1:0] param_hold;
  logic [DATA_W-1:0] delay_hold;
  logic [DATA_W-1:0] slot_command  [QUEUE_SLOTS];
  logic [DATA_W-1:0] slot_param_in [QUEUE_SLOTS];
  logic [DATA_W-1:0] slot_param_out[QUEUE_SLOTS];
  logic [DATA_W-1:0] slot_deadline [QUEUE_SLOTS];
  logic [DATA_W-1:0] cur_command;
  logic [DATA_W-1:0] cur_deadline;

  assign cur_command  = slot_command[ctrl.idx];
  assign cur_deadline = slot_deadline[ctrl.idx];

  always_comb begin
    status.slot_free = (cur_command == '0) || (cur_deadline == '0);
    status.slot_due  = (cur_command != '0) && (cur_deadline <= time_now);
  end

  always_ff @(posedge clk) begin
    if (ctrl.latch) begin
      cmd_hold   <= command;
      param_hold <= param_handle;
      delay_hold <= delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now <= '0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        slot_command[i]  <= '0;
        slot_deadline[i] <= '0;
      end
    end else begin
      case (ctrl.act)
        ACT_TIME_INC: time_now <= time_now + 1'b1;
        ACT_INSERT: begin
          slot_command[ctrl.idx]  <= cmd_hold;
          slot_deadline[ctrl.idx] <= time_now + delay_hold;
        end
        ACT_CLEAR: begin
          slot_command[ctrl.idx]  <= '0;
          slot_deadline[ctrl.idx] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_INSERT) begin
      slot_param_in[ctrl.idx]  <= param_hold;
      slot_param_out[ctrl.idx] <= reply_handle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (ctrl.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.emit)
      EMIT_OK: begin
        success       <= 1'b1;
        due_command   <= '0;
        due_param_in  <= '0;
        due_param_out <= '0;
      end
      EMIT_SLOT: begin
        success       <= 1'b1;
        due_command   <= cur_command;
        due_param_in  <= slot_param_in[ctrl.idx];
        due_param_out <= slot_param_out[ctrl.idx];
      end
      EMIT_ZERO: begin
        success       <= 1'b0;
        due_command   <= '0;
        due_param_in  <= '0;
        due_param_out <= '0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/delayed_command_slot_queue.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue
// Timer-driven table of delayed commands run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; op selects a tick, an
// insert of command, param_handle and delay, or a fetch of the lowest due slot.
// Every item gives exactly one result beat, marked by done for one cycle, on
// success, due_command, due_param_in and due_param_out.
// A tick gives its beat from the tick step. An insert or a fetch scans the
// slot table one slot per cycle, then gives its beat from the write, read or
// empty step; an unused op code gives an all-zero beat from the empty step.
// The next item can be accepted in the cycle its result beat is shown.
// The reply handle register sits at byte address 0 of the APB port and is
// stored with every insert; it must be written only while the block is idle,
// which the block itself does not enforce. Reset clears the time counter,
// slot commands and deadlines, the reply handle and the sequencer.
// The receiver cannot stall, so each beat is taken as it appears.
`timescale 1ns / 1ps
`default_nettype none

module delayed_command_slot_queue import dcsq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [DATA_W-1:0]  command,
  input  logic [DATA_W-1:0]  param_handle,
  input  logic [DATA_W-1:0]  delay,
  output logic               done,
  output logic               success,
  output logic [DATA_W-1:0]  due_command,
  output logic [DATA_W-1:0]  due_param_in,
  output logic [DATA_W-1:0]  due_param_out,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [DATA_W-1:0] reply_handle;
  dp_ctrl_t          ctrl;
  dp_status_t        status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_handle <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1] == REG_REPLY_HANDLE)) begin
      reply_handle <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1] == REG_REPLY_HANDLE) begin
      prdata = reply_handle;
    end
  end

  dcsq_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl)
  );

  dcsq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .command       (command),
    .param_handle  (param_handle),
    .delay         (delay),
    .reply_handle  (reply_handle),
    .status        (status),
    .done          (done),
    .success       (success),
    .due_command   (due_command),
    .due_param_in  (due_param_in),
    .due_param_out (due_param_out)
  );

endmodule

`default_nettype wire

// ===== rtl/dcsq_checker.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue checker
// Port-level checks on the command handshake and the result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "delayed_command_slot_queue_defines.svh"

module dcsq_checker import dcsq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic              success,
  input wire logic [DATA_W-1:0] due_command,
  input wire logic [DATA_W-1:0] due_param_in,
  input wire logic [DATA_W-1:0] due_param_out
);

  `DCSQ_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted item did not raise busy")
  `DCSQ_ASSERT(a_single_beat, clk, rst, done |=> !done, "result beat lasted more than one cycle")
  `DCSQ_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result beat shown while still busy")
  `DCSQ_ASSERT(a_fail_zero, clk, rst, (done && !success) |-> ((due_command == '0) && (due_param_in == '0) && (due_param_out == '0)), "failed beat carried data")
  `DCSQ_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> (!done && !busy), "block not quiet after reset")

endmodule

bind delayed_command_slot_queue dcsq_checker u_dcsq_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Delayed command slot queue testbench
// Drives ticks, inserts and fetches through the start/busy port and sets the
// reply handle over APB between phases. A scoreboard keeps its own copy of the
// time counter and slot table, predicts one result beat per accepted item and
// compares every done beat field by field. A directed opening covers empty and
// full tables, zero commands, zero and wrapped deadlines and the unused op
// code; random phases follow with random gaps and bursts without gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import dcsq_pkg::*;

typedef struct packed {
  logic              success;
  logic [DATA_W-1:0] command;
  logic [DATA_W-1:0] param_in;
  logic [DATA_W-1:0] param_out;
} due_reply_t;

class delay_table_tracker;
  logic [DATA_W-1:0] now_ms;
  logic [DATA_W-1:0] reply_handle;
  logic [DATA_W-1:0] cmd_tab      [QUEUE_SLOTS];
  logic [DATA_W-1:0] pin_tab      [QUEUE_SLOTS];
  logic [DATA_W-1:0] pout_tab     [QUEUE_SLOTS];
  logic [DATA_W-1:0] deadline_tab [QUEUE_SLOTS];
  due_reply_t        expected_replies [$];
  int                errors;

  function new();
    now_ms       = '0;
    reply_handle = '0;
    errors       = 0;
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      cmd_tab[i]      = '0;
      pin_tab[i]      = '0;
      pout_tab[i]     = '0;
      deadline_tab[i] = '0;
    end
  endfunction

  function void set_reply_handle(input logic [DATA_W-1:0] value);
    reply_handle = value;
  endfunction

  function void note_item(input logic [1:0] item_op, input logic [DATA_W-1:0] cmd,
                          input logic [DATA_W-1:0] pin, input logic [DATA_W-1:0] dly);
    due_reply_t r;
    logic       hit;
    r   = '0;
    hit = 1'b0;
    case (item_op)
      OP_TICK: begin
        now_ms    = now_ms + 1;
        r.success = 1'b1;
      end
      OP_INSERT: begin
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
          if (!hit && (cmd_tab[i] == '0 || deadline_tab[i] == '0)) begin
            cmd_tab[i]      = cmd;
            pin_tab[i]      = pin;
            pout_tab[i]     = reply_handle;
            deadline_tab[i] = now_ms + dly;
            hit             = 1'b1;
          end
        end
        r.success = hit;
      end
      OP_FETCH: begin
        for (int i = 0; i < QUEUE_SLOTS; i++) begin
          if (!hit && cmd_tab[i] != '0 && deadline_tab[i] <= now_ms) begin
            r.command       = cmd_tab[i];
            r.param_in      = pin_tab[i];
            r.param_out     = pout_tab[i];
            cmd_tab[i]      = '0;
            deadline_tab[i] = '0;
            hit             = 1'b1;
          end
        end
        r.success = hit;
      end
      default: begin
      end
    endcase
    expected_replies.push_back(r);
  endfunction

  function void check_beat(input logic ok, input logic [DATA_W-1:0] cmd,
                           input logic [DATA_W-1:0] pin, input logic [DATA_W-1:0] pout);
    due_reply_t exp;
    if (expected_replies.size() == 0) begin
      $error("result beat with no item pending");
      errors++;
      return;
    end
    exp = expected_replies.pop_front();
    if (ok !== exp.success) begin
      $error("success: expected %0h, actual %0h", exp.success, ok);
      errors++;
    end
    if (cmd !== exp.command) begin
      $error("due_command: expected %08h, actual %08h", exp.command, cmd);
      errors++;
    end
    if (pin !== exp.param_in) begin
      $error("due_param_in: expected %08h, actual %08h", exp.param_in, pin);
      errors++;
    end
    if (pout !== exp.param_out) begin
      $error("due_param_out: expected %08h, actual %08h", exp.param_out, pout);
      errors++;
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0]         OP_UNUSED         = 2'd3;
  localparam logic [PADDR_W-1:0] ADDR_REPLY_HANDLE = PADDR_W'(4 * int'(REG_REPLY_HANDLE));
  localparam int ITEMS_PER_PHASE = 90;
  localparam int RANDOM_PHASES   = 5;
  localparam int SETTLE_CYCLES   = 16;
  localparam int CYCLE_LIMIT     = 200000;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               start         = 1'b0;
  logic [1:0]         op            = '0;
  logic [DATA_W-1:0]  command       = '0;
  logic [DATA_W-1:0]  param_handle  = '0;
  logic [DATA_W-1:0]  delay         = '0;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [PADDR_W-1:0] paddr         = '0;
  logic [DATA_W-1:0]  pwdata        = '0;
  logic               busy;
  logic               done;
  logic               success;
  logic [DATA_W-1:0]  due_command;
  logic [DATA_W-1:0]  due_param_in;
  logic [DATA_W-1:0]  due_param_out;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  delay_table_tracker tracker;
  int                 burst_left = 0;
  int                 cycles     = 0;

  delayed_command_slot_queue i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .command       (command),
    .param_handle  (param_handle),
    .delay         (delay),
    .done          (done),
    .success       (success),
    .due_command   (due_command),
    .due_param_in  (due_param_in),
    .due_param_out (due_param_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_beat(success, due_command, due_param_in, due_param_out);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  task automatic send_item(input logic [1:0] item_op, input logic [DATA_W-1:0] cmd,
                           input logic [DATA_W-1:0] pin, input logic [DATA_W-1:0] dly,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    op           <= item_op;
    command      <= cmd;
    param_handle <= pin;
    delay        <= dly;
    do @(posedge clk); while (busy !== 1'b0);
    tracker.note_item(item_op, cmd, pin, dly);
  endtask

  task automatic send_random_item();
    int                pick;
    int                dsel;
    int                csel;
    logic [1:0]        item_op;
    logic [DATA_W-1:0] cmd;
    logic [DATA_W-1:0] dly;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      item_op = OP_TICK;
    end else if (pick < 65) begin
      item_op = OP_INSERT;
    end else if (pick < 95) begin
      item_op = OP_FETCH;
    end else begin
      item_op = OP_UNUSED;
    end
    csel = $urandom_range(0, 9);
    case (csel)
      0:       cmd = '0;
      1:       cmd = '1;
      2:       cmd = $urandom_range(1, 15);
      default: cmd = $urandom;
    endcase
    dsel = $urandom_range(0, 9);
    if (dsel < 7) begin
      dly = $urandom_range(0, 15);
    end else if (dsel == 7) begin
      dly = $urandom;
    end else if (dsel == 8) begin
      dly = '0 - tracker.now_ms;
    end else begin
      dly = 32'hFFFF_FFFF - $urandom_range(0, 3);
    end
    send_item(item_op, cmd, $urandom, dly, next_gap());
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reply_handle(input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_REPLY_HANDLE;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reply_handle(value);
  endtask

  initial begin
    tracker = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reply_handle(32'hFFFF_FFFF);
    send_item(OP_FETCH, '0, '0, '0, next_gap());
    send_item(OP_UNUSED, '1, '1, '1, next_gap());
    send_item(OP_INSERT, '1, '1, '0, next_gap());
    send_item(OP_INSERT, 32'h1, '0, '0, next_gap());
    send_item(OP_FETCH, '1, '1, '1, next_gap());
    send_item(OP_TICK, '1, '1, '1, next_gap());
    send_item(OP_INSERT, 32'h1234_5678, 32'hCAFE_0001, 32'd3, next_gap());
    send_item(OP_FETCH, '0, '0, '0, next_gap());
    send_item(OP_INSERT, '0, 32'h5A5A_A5A5, 32'd5, next_gap());
    repeat (3) send_item(OP_TICK, '0, '0, '0, next_gap());
    send_item(OP_FETCH, '0, '0, '0, next_gap());
    send_item(OP_FETCH, '0, '0, '0, next_gap());
    send_item(OP_INSERT, '1, 32'h0BAD_F00D, 32'hFFFF_FFFC, next_gap());
    send_item(OP_INSERT, 32'hAAAA_5555, 32'h5555_AAAA, '1, next_gap());
    for (int i = 0; i < QUEUE_SLOTS; i++) begin
      send_item(OP_INSERT, 32'h100 + i, $urandom, 32'd2, next_gap());
    end
    send_item(OP_FETCH, '0, '0, '0, next_gap());
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       write_reply_handle('0);
        1:       write_reply_handle('1);
        2:       write_reply_handle(32'h5555_AAAA);
        default: write_reply_handle($urandom);
      endcase
      repeat (ITEMS_PER_PHASE) send_random_item();
      drain();
    end

    if (tracker.errors == 0 && tracker.expected_replies.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
